/* design/gzhp_pkg.sv */
// Shared types, constants and helpers for the gzip header parser.
`timescale 1ns / 1ps
package gzhp_pkg;

   localparam int HDR_LENGTH_BITS = 32;
   localparam int RSP_LENGTH_BITS = 32;

   localparam logic [7:0] GZ_ID1      = 8'h1f;
   localparam logic [7:0] GZ_ID2      = 8'h8b;
   localparam logic [7:0] GZ_CM       = 8'h08;
   localparam logic [7:0] GZ_RESERVED = 8'he0;
   localparam logic [4:0] GZ_FHCRC    = 5'h02;
   localparam logic [4:0] GZ_FEXTRA   = 5'h04;
   localparam logic [4:0] GZ_FNAME    = 5'h08;
   localparam logic [4:0] GZ_FCOMMENT = 5'h10;

   localparam logic [3:0] IDX_ID1   = 4'd0;
   localparam logic [3:0] IDX_ID2   = 4'd1;
   localparam logic [3:0] IDX_CM    = 4'd2;
   localparam logic [3:0] IDX_FLG   = 4'd3;
   localparam logic [3:0] IDX_LAST  = 4'd9;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_FIXED,
      PH_XLEN0,
      PH_XLEN1,
      PH_EXTRA,
      PH_NAME,
      PH_COMMENT,
      PH_HCRC0,
      PH_HCRC1,
      PH_COMPLETE
   } phase_type;

   typedef enum logic [1:0] {
      SEC_AFTER_FIXED,
      SEC_AFTER_EXTRA,
      SEC_AFTER_NAME,
      SEC_AFTER_COMMENT
   } section_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  fixed_index;
      logic [4:0]  flags;
      logic [15:0] extra;
   } parse_state_type;

   typedef struct packed {
      logic emit;
      logic ok;
   } outcome_type;

   function automatic phase_type next_section(input section_type sec, input logic [4:0] flags);
      phase_type ph;
      if (sec == SEC_AFTER_FIXED && (flags & GZ_FEXTRA) != 5'd0)
         ph = PH_XLEN0;
      else if (sec != SEC_AFTER_NAME && sec != SEC_AFTER_COMMENT
               && (flags & GZ_FNAME) != 5'd0)
         ph = PH_NAME;
      else if (sec != SEC_AFTER_COMMENT && (flags & GZ_FCOMMENT) != 5'd0)
         ph = PH_COMMENT;
      else if ((flags & GZ_FHCRC) != 5'd0)
         ph = PH_HCRC0;
      else
         ph = PH_COMPLETE;
      return ph;
   endfunction

endpackage

/* design/gzhp_step.sv */
// One-byte header parse step: current state and byte in, next state and outcome out.
`timescale 1ns / 1ps
module gzhp_step #(
   parameter int LENGTH_BITS = gzhp_pkg::HDR_LENGTH_BITS
) (
   input  gzhp_pkg::parse_state_type cur_state,
   input  logic [((LENGTH_BITS < 32) ? LENGTH_BITS : 32)-1:0] cur_pos,
   input  logic [7:0]                data_byte,
   input  logic                      first_byte,
   input  logic                      last_byte,
   output gzhp_pkg::parse_state_type nxt_state,
   output logic [((LENGTH_BITS < 32) ? LENGTH_BITS : 32)-1:0] nxt_pos,
   output gzhp_pkg::outcome_type     outcome,
   output logic [gzhp_pkg::RSP_LENGTH_BITS-1:0] length
);
   import gzhp_pkg::*;

   localparam int CountBits = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

   parse_state_type      st;
   parse_state_type      upd;
   logic [CountBits-1:0] pos;
   logic [CountBits-1:0] n;
   logic                 fail;
   logic [15:0]          ext;

   always_comb begin
      st  = cur_state;
      pos = cur_pos;
      if (first_byte) begin
         st.phase       = PH_FIXED;
         st.fixed_index = 4'd0;
         st.flags       = 5'd0;
         st.extra       = 16'd0;
         pos            = '0;
      end

      upd       = st;
      fail      = 1'b0;
      n         = pos + {{(CountBits-1){1'b0}}, 1'b1};
      ext       = 16'd0;
      nxt_state = st;
      nxt_pos   = pos;
      outcome   = '0;
      length    = '0;

      if (st.phase != PH_IDLE) begin
         if (pos == {CountBits{1'b1}}) begin
            fail = 1'b1;
         end else begin
            case (st.phase)
               PH_FIXED: begin
                  if (st.fixed_index == IDX_ID1 && data_byte != GZ_ID1)
                     fail = 1'b1;
                  else if (st.fixed_index == IDX_ID2 && data_byte != GZ_ID2)
                     fail = 1'b1;
                  else if (st.fixed_index == IDX_CM && data_byte != GZ_CM)
                     fail = 1'b1;
                  else if (st.fixed_index == IDX_FLG) begin
                     if ((data_byte & GZ_RESERVED) != 8'd0)
                        fail = 1'b1;
                     else
                        upd.flags = data_byte[4:0];
                  end
                  if (!fail) begin
                     if (st.fixed_index >= IDX_LAST)
                        upd.phase = next_section(SEC_AFTER_FIXED, upd.flags);
                     else
                        upd.fixed_index = st.fixed_index + 4'd1;
                  end
               end
               PH_XLEN0: begin
                  upd.extra = {8'd0, data_byte};
                  upd.phase = PH_XLEN1;
               end
               PH_XLEN1: begin
                  ext       = {data_byte, st.extra[7:0]};
                  upd.extra = ext;
                  upd.phase = (ext == 16'd0) ? next_section(SEC_AFTER_EXTRA, st.flags)
                                             : PH_EXTRA;
               end
               PH_EXTRA: begin
                  ext       = st.extra - 16'd1;
                  upd.extra = ext;
                  if (ext == 16'd0)
                     upd.phase = next_section(SEC_AFTER_EXTRA, st.flags);
               end
               PH_NAME: begin
                  if (data_byte == 8'd0)
                     upd.phase = next_section(SEC_AFTER_NAME, st.flags);
               end
               PH_COMMENT: begin
                  if (data_byte == 8'd0)
                     upd.phase = next_section(SEC_AFTER_COMMENT, st.flags);
               end
               PH_HCRC0: upd.phase = PH_HCRC1;
               PH_HCRC1: upd.phase = PH_COMPLETE;
               default:  fail = 1'b1;
            endcase
         end

         if (!fail && upd.phase == PH_COMPLETE) begin
            outcome.emit    = 1'b1;
            outcome.ok      = 1'b1;
            length          = RSP_LENGTH_BITS'(n);
            nxt_state       = upd;
            nxt_state.phase = PH_IDLE;
         end else if (fail || last_byte) begin
            outcome.emit    = 1'b1;
            nxt_state       = upd;
            nxt_state.phase = PH_IDLE;
         end else begin
            nxt_state = upd;
            nxt_pos   = n;
         end
      end
   end

endmodule

/* design/gzip_header_parser.sv */
// Top level of the gzip member header parser: request register, parse step, result register.
// Each byte is held in the request register; any outcome then goes to the result register.
// Throughput: one byte per cycle unless stalled; the parse state updates once per byte.
// A full result register with rsp_ready low stalls the request register.
// Reset (synchronous, active high) empties both registers and returns the parser to idle.
`timescale 1ns / 1ps
module gzip_header_parser #(
   parameter int LENGTH_BITS = gzhp_pkg::HDR_LENGTH_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_first_byte,
   input  logic                                  req_last_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_header_ok,
   output logic [gzhp_pkg::RSP_LENGTH_BITS-1:0]  rsp_header_length
);
   import gzhp_pkg::*;

   localparam int CountBits = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

   logic                       req_valid_ff;
   logic [7:0]                 req_data_ff;
   logic                       req_first_ff;
   logic                       req_last_ff;
   parse_state_type            state_ff;
   parse_state_type            state_in;
   logic [CountBits-1:0]       pos_ff;
   logic [CountBits-1:0]       pos_in;
   outcome_type                outcome;
   logic [RSP_LENGTH_BITS-1:0] length_in;
   logic                       rsp_valid_ff;
   logic                       rsp_ok_ff;
   logic [RSP_LENGTH_BITS-1:0] rsp_length_ff;
   logic                       advance;

   gzhp_step #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_step (
      .cur_state (state_ff),
      .cur_pos   (pos_ff),
      .data_byte (req_data_ff),
      .first_byte(req_first_ff),
      .last_byte (req_last_ff),
      .nxt_state (state_in),
      .nxt_pos   (pos_in),
      .outcome   (outcome),
      .length    (length_in)
   );

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_IDLE, fixed_index: 4'd0, flags: 5'd0, extra: 16'd0};
         pos_ff       <= '0;
      end else begin
         if (req_valid && req_ready)
            req_valid_ff <= 1'b1;
         else if (advance)
            req_valid_ff <= 1'b0;

         if (advance) begin
            state_ff     <= state_in;
            pos_ff       <= pos_in;
            rsp_valid_ff <= outcome.emit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff  <= req_data_byte;
         req_first_ff <= req_first_byte;
         req_last_ff  <= req_last_byte;
      end
      if (advance && outcome.emit) begin
         rsp_ok_ff     <= outcome.ok;
         rsp_length_ff <= length_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_header_ok     = rsp_ok_ff;
   assign rsp_header_length = rsp_length_ff;

endmodule

/* tb/gzip_header_parser_tb.sv */
// Testbench for gzip_header_parser: directed and random gzip headers, checked against a predictor.
`timescale 1ns / 1ps
module gzip_header_parser_tb;
   import gzhp_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 300;
   localparam int LIVE_TARGET = 1800;
   localparam int HOLD_MEMBERS = 30;
   localparam longint unsigned COUNT_LIMIT = (HDR_LENGTH_BITS >= 32) ? 64'hFFFF_FFFF :
                                             (64'd1 << HDR_LENGTH_BITS) - 64'd1;

   typedef struct {
      logic        ok;
      logic [31:0] length;
   } header_outcome_type;

   class header_scoreboard;
      phase_type          phase;
      logic [3:0]         fixed_idx;
      logic [4:0]         flg;
      logic [15:0]        xlen;
      logic [63:0]        pos;
      header_outcome_type outcome_q[$];
      int                 errors;
      int                 live_items;
      int                 ok_seen;
      int                 fail_seen;

      function new();
         phase = PH_IDLE;
         fixed_idx = '0;
         flg = '0;
         xlen = '0;
         pos = '0;
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction

      function phase_type after_section(section_type passed);
         if (passed == SEC_AFTER_FIXED && (flg & GZ_FEXTRA) != 5'd0)
            return PH_XLEN0;
         if (passed <= SEC_AFTER_EXTRA && (flg & GZ_FNAME) != 5'd0)
            return PH_NAME;
         if (passed <= SEC_AFTER_NAME && (flg & GZ_FCOMMENT) != 5'd0)
            return PH_COMMENT;
         if ((flg & GZ_FHCRC) != 5'd0)
            return PH_HCRC0;
         return PH_COMPLETE;
      endfunction

      function void note_request(logic [7:0] data, logic first, logic last);
         logic               fail;
         phase_type          nxt;
         logic [63:0]        n;
         header_outcome_type res;
         if (first) begin
            phase = PH_FIXED;
            fixed_idx = '0;
            flg = '0;
            xlen = '0;
            pos = '0;
         end
         if (phase == PH_IDLE)
            return;
         live_items++;
         fail = 1'b0;
         nxt = phase;
         n = '0;
         if (pos >= COUNT_LIMIT) begin
            fail = 1'b1;
         end else begin
            n = pos + 64'd1;
            case (phase)
               PH_FIXED: begin
                  case (fixed_idx)
                     IDX_ID1: fail = (data != GZ_ID1);
                     IDX_ID2: fail = (data != GZ_ID2);
                     IDX_CM:  fail = (data != GZ_CM);
                     IDX_FLG: begin
                        if ((data & GZ_RESERVED) != 8'h00)
                           fail = 1'b1;
                        else
                           flg = data[4:0];
                     end
                     default: ;
                  endcase
                  if (!fail) begin
                     if (fixed_idx >= IDX_LAST)
                        nxt = after_section(SEC_AFTER_FIXED);
                     else
                        fixed_idx = fixed_idx + 4'd1;
                  end
               end
               PH_XLEN0: begin
                  xlen = {8'h00, data};
                  nxt = PH_XLEN1;
               end
               PH_XLEN1: begin
                  xlen = {data, xlen[7:0]};
                  nxt = (xlen == 16'd0) ? after_section(SEC_AFTER_EXTRA) : PH_EXTRA;
               end
               PH_EXTRA: begin
                  xlen = xlen - 16'd1;
                  if (xlen == 16'd0)
                     nxt = after_section(SEC_AFTER_EXTRA);
               end
               PH_NAME:    if (data == 8'h00) nxt = after_section(SEC_AFTER_NAME);
               PH_COMMENT: if (data == 8'h00) nxt = after_section(SEC_AFTER_COMMENT);
               PH_HCRC0:   nxt = PH_HCRC1;
               PH_HCRC1:   nxt = PH_COMPLETE;
               default:    fail = 1'b1;
            endcase
         end
         if (!fail && nxt == PH_COMPLETE) begin
            res.ok = 1'b1;
            res.length = n[31:0];
            outcome_q = {outcome_q, res};
            phase = PH_IDLE;
         end else if (fail || last) begin
            res.ok = 1'b0;
            res.length = '0;
            outcome_q = {outcome_q, res};
            phase = PH_IDLE;
         end else begin
            phase = nxt;
            pos = n;
         end
      endfunction

      task report_mismatch(string what);
         $display("%0t mismatch: %s", $time, what);
         errors++;
      endtask

      task check_result(logic ok, logic [31:0] length);
         header_outcome_type want;
         if (outcome_q.size() == 0) begin
            report_mismatch($sformatf("unexpected outcome ok=%0b length=%0d", ok, length));
            return;
         end
         want = outcome_q.pop_front();
         if (want.ok) ok_seen++;
         else fail_seen++;
         if (ok !== want.ok)
            report_mismatch($sformatf("header_ok %0b, want %0b", ok, want.ok));
         if (length !== want.length)
            report_mismatch($sformatf("header_length %0d, want %0d", length, want.length));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_first_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_header_ok;
   logic [RSP_LENGTH_BITS-1:0] rsp_header_length;

   header_scoreboard sb = new();
   int burst_left = 0;
   int holds_requested = 0;
   int holds_done = 0;

   gzip_header_parser DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_first_byte    (req_first_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_header_ok     (rsp_header_ok),
      .rsp_header_length (rsp_header_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_data_byte, req_first_byte, req_last_byte);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_header_ok, rsp_header_length);
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   // result side: segments of random stall density, plus requested long holds
   initial begin : receiver
      int left;
      int stall_pct;
      left = 0;
      stall_pct = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != holds_requested) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         if (left == 0) begin
            left = $urandom_range(10, 80);
            case ($urandom_range(3))
               0: stall_pct = 0;
               1: stall_pct = 25;
               2: stall_pct = 50;
               default: stall_pct = 90;
            endcase
         end
         left--;
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_request(input logic [7:0] data, input logic first, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(4) == 0) ? 150 : $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_first_byte <= first;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_seq(input logic [7:0] seq[$], input logic last_on_end);
      foreach (seq[i])
         send_request(seq[i], i == 0, last_on_end && i == seq.size() - 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // receiver holds off while short failing members pile up behind it
   task automatic hold_pressure();
      holds_requested++;
      burst_left = 2 * HOLD_MEMBERS;
      repeat (HOLD_MEMBERS)
         send_request(GZ_ID1 ^ 8'($urandom_range(1, 255)), 1'b1, 1'($urandom_range(1)));
      req_valid <= 1'b0;
      while (holds_done != holds_requested) @(posedge clock);
      drain();
   endtask

   task automatic send_member();
      logic [7:0] hdr[$];
      int kind;
      int flg;
      int xlen;
      int idx;
      int cut;
      int last_at;
      int trail;
      kind = $urandom_range(99);
      if (kind < 5) begin
         repeat ($urandom_range(1, 6))
            send_request(8'($urandom), $urandom_range(9) == 0, $urandom_range(9) == 0);
         return;
      end
      flg = $urandom_range(31);
      hdr = {GZ_ID1, GZ_ID2, GZ_CM, 8'(flg)};
      repeat (6) hdr = {hdr, 8'($urandom)};
      if (kind < 15) begin
         idx = $urandom_range(3);
         if (idx < 3)
            hdr[idx] = hdr[idx] ^ 8'($urandom_range(1, 255));
         else
            hdr[3] = hdr[3] | {3'($urandom_range(1, 7)), 5'b0};
      end
      if ((5'(flg) & GZ_FEXTRA) != 5'd0) begin
         case ($urandom_range(9))
            0, 1, 2: xlen = 0;
            9:       xlen = 256 + $urandom_range(0, 40);
            default: xlen = $urandom_range(1, 12);
         endcase
         hdr = {hdr, 8'(xlen)};
         hdr = {hdr, 8'(xlen >> 8)};
         repeat (xlen) hdr = {hdr, 8'($urandom)};
      end
      if ((5'(flg) & GZ_FNAME) != 5'd0) begin
         repeat ($urandom_range(0, 10)) hdr = {hdr, 8'($urandom_range(1, 255))};
         hdr = {hdr, 8'h00};
      end
      if ((5'(flg) & GZ_FCOMMENT) != 5'd0) begin
         repeat ($urandom_range(0, 10)) hdr = {hdr, 8'($urandom_range(1, 255))};
         hdr = {hdr, 8'h00};
      end
      if ((5'(flg) & GZ_FHCRC) != 5'd0)
         repeat (2) hdr = {hdr, 8'($urandom)};
      cut = hdr.size();
      last_at = -1;
      trail = 0;
      if (kind < 25) begin
         last_at = $urandom_range(0, hdr.size() - 2);
         cut = last_at + 1;
      end else if (kind < 35) begin
         // abandoned mid-header; the next member restarts the parse
         cut = $urandom_range(1, hdr.size() - 1);
      end else begin
         if ($urandom_range(3) == 0)
            last_at = hdr.size() - 1;
         trail = $urandom_range(0, 4);
      end
      for (int i = 0; i < cut; i++)
         send_request(hdr[i], i == 0, i == last_at);
      for (int i = 0; i < trail; i++)
         send_request(8'($urandom), 1'b0, i == trail - 1 && $urandom_range(2) == 0);
   endtask

   initial begin : stimulus
      int members;
      bit mid_hold;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_first_byte = 1'b0;
      req_last_byte = 1'b0;
      members = 0;
      mid_hold = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // stray byte while idle, each check failing, truncation, minimal FTEXT header
      send_request(GZ_ID1, 1'b0, 1'b0);
      send_seq({8'h00}, 1'b0);
      send_seq({GZ_ID1, 8'h00}, 1'b0);
      send_seq({GZ_ID1, GZ_ID2, 8'h07}, 1'b0);
      send_seq({GZ_ID1, GZ_ID2, GZ_CM, 8'h80}, 1'b0);
      send_seq({GZ_ID1, GZ_ID2}, 1'b1);
      send_seq({GZ_ID1, GZ_ID2, GZ_CM, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff},
               1'b1);
      drain();

      hold_pressure();

      while (sb.live_items < LIVE_TARGET) begin
         send_member();
         members++;
         if (members % 150 == 0)
            drain();
         if (!mid_hold && sb.live_items >= LIVE_TARGET / 2) begin
            mid_hold = 1'b1;
            hold_pressure();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d parsed bytes over %0d random members and %0d receiver holds",
               sb.live_items, members, holds_done);
      $display("outcomes: %0d headers ok, %0d rejected or truncated, %0d mismatches",
               sb.ok_seen, sb.fail_seen, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
